@@ src/mkdp_pkg.sv @@
// Package for the multi-key debounce block: sizes, op codes and word types.
`default_nettype none
package mkdp_pkg;

  // Key count and field widths
  localparam int NUM_KEYS = 3;
  localparam int CNT_W    = 4;
  localparam int CODE_W   = 2;
  localparam logic [CNT_W-1:0] TARGET_RESET = CNT_W'(3);

  // Operation codes
  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_SCAN = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Input word
  typedef struct packed {
    op_t                 op;
    logic [NUM_KEYS-1:0] pressed_bits;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [CODE_W-1:0]   event_code;
    logic [NUM_KEYS-1:0] stable_bits;
  } out_word_t;

  // Per-lane status toward the merge stage
  typedef struct packed {
    logic press;     // confirmed a new press this word
    logic level_nxt; // confirmed level after this word
  } lane_stat_t;

endpackage
`default_nettype wire

@@ src/mkdp_lane.sv @@
// One debounce lane: last sample, run counter and confirmed level of one key.
`default_nettype none
module mkdp_lane
  import mkdp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire op_t              op,
  input  wire logic             sample,
  input  wire logic [CNT_W-1:0] target,
  output lane_stat_t            stat
);

  logic             last_r, last_nxt;
  logic             conf_r, conf_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;

  // Next state for the current word
  always_comb begin
    last_nxt   = last_r;
    conf_nxt   = conf_r;
    cnt_nxt    = cnt_r;
    stat.press = 1'b0;
    unique case (op)
      OP_INIT: begin
        last_nxt = sample;
        conf_nxt = sample;
        cnt_nxt  = '0;
      end
      OP_SCAN: begin
        if (sample == last_r) begin
          // saturate at the target
          if (cnt_r < target) cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          last_nxt = sample;
          cnt_nxt  = CNT_W'(1);
        end
        if (cnt_nxt >= target && sample != conf_r) begin
          conf_nxt   = sample;
          stat.press = sample;
        end
      end
      default: begin
      end
    endcase
    stat.level_nxt = conf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b1;
      conf_r <= 1'b1;
      cnt_r  <= '0;
    end else if (en) begin
      last_r <= last_nxt;
      conf_r <= conf_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/mkdp_merge.sv @@
// Merge stage: picks the winning press across lanes and holds the event latch.
`default_nettype none
module mkdp_merge
  import mkdp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire op_t               op,
  input  wire lane_stat_t        stat [NUM_KEYS],
  output logic [CODE_W-1:0]      event_code,
  output logic [NUM_KEYS-1:0]    stable_bits
);

  logic [CODE_W-1:0] pend_r, pend_nxt;
  logic [CODE_W-1:0] win_code;
  logic              win_any;

  // Highest-numbered confirming key wins
  always_comb begin
    win_code = '0;
    win_any  = 1'b0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      stable_bits[i] = stat[i].level_nxt;
      if (stat[i].press) begin
        win_code = CODE_W'(i + 1);
        win_any  = 1'b1;
      end
    end
  end

  // Event latch update and read-out
  always_comb begin
    pend_nxt   = pend_r;
    event_code = '0;
    unique case (op)
      OP_INIT: pend_nxt = '0;
      OP_SCAN: if (win_any) pend_nxt = win_code;
      OP_READ: begin
        event_code = pend_r;
        pend_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (en) begin
      pend_r <= pend_nxt;
    end
  end

  // Read returns nothing on other ops
  a_code_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    event_code != '0 |-> op == OP_READ)
    else $error("event code outside read");

  // Init and read leave the latch empty
  a_clear_after_init_read: assert property (@(posedge clk) disable iff (!rst_n)
    en && (op == OP_INIT || op == OP_READ) |=> pend_r == '0)
    else $error("event latch not cleared");

endmodule
`default_nettype wire

@@ src/multi_key_debounce_press_latch.sv @@
// Top level of the multi-key debounce block with a one-entry press-event latch.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one word per op: init
//   from samples, scan tick or read-and-clear of the event latch. Each word
//   gives exactly one result word on out_valid/out_stall/out_data with the
//   event code (read only) and the confirmed level of every key.
//   All keys are processed in parallel lanes in the cycle a word is accepted;
//   the result is registered, and one word is taken every cycle while the
//   output drains.
//   A skid register behind the output register absorbs one word when the
//   receiver stalls; in_stall is raised only while the skid holds a word.
//   cfg_data writes the debounce target (number of equal samples needed); the
//   port is always ready and is meant to be written while the block is idle.
//   Reset (rst_n low, synchronous) sets all keys to pressed-and-confirmed
//   levels, clears counters and the event latch, and loads a target of 3.
`default_nettype none
module multi_key_debounce_press_latch
  import mkdp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_word_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_word_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0] target_r;
  logic             in_fire, out_fire;
  lane_stat_t       stat [NUM_KEYS];
  out_word_t        res;
  out_word_t        out_r, skid_r;
  logic             out_valid_r, skid_valid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Debounce target register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      target_r <= cfg_data;
    end
  end

  // One lane per key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    mkdp_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (in_fire),
      .op     (in_data.op),
      .sample (in_data.pressed_bits[k]),
      .target (target_r),
      .stat   (stat[k])
    );
  end

  // Merge lanes into the result word
  mkdp_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (in_fire),
    .op          (in_data.op),
    .stat        (stat),
    .event_code  (res.event_code),
    .stable_bits (res.stable_bits)
  );

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  // Skid is only used behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word with empty output");

  // An accepted word with a free output shows up next cycle
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !skid_valid_r |=> out_valid_r)
    else $error("accepted word lost");

  // Input stalls only after output back-pressure
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid_r && out_stall))
    else $error("input stalled without back-pressure");

endmodule
`default_nettype wire
